[rtl/qrpm_pkg.sv]
// qrpm_pkg: constants, types and helper functions for the qr module placement masker
// no dependencies; used by every other file of the block
`default_nettype none

package qrpm_pkg;

    // grid geometry of a version-1 symbol
    localparam int unsigned GRID       = 21;
    localparam int unsigned LAST_IDX   = GRID - 1;
    localparam int unsigned FMT_LINE   = 8;   // format row and column
    localparam int unsigned TIMING     = 6;   // timing row and column
    localparam int unsigned FINDER_HI  = 12;  // finder corners start past this index
    localparam int unsigned PAIR_STEP  = 2;
    localparam int unsigned LAST_PAIR  = 2;   // right column of the last pair is at most this

    localparam int unsigned COORD_W    = 5;
    localparam int unsigned MASK_W     = 4;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned VALUE_W    = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 2'd2;

    // input operations
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_PLACE   = 1'b1;

    // result values
    localparam logic [VALUE_W-1:0] VAL_LIGHT   = 3'd0;
    localparam logic [VALUE_W-1:0] VAL_PAYLOAD = 3'd1;
    localparam logic [VALUE_W-1:0] VAL_PADDING = 3'd4;

    // mask pattern codes
    localparam logic [MASK_W-1:0] MASK_RC_SUM2   = 4'd0;
    localparam logic [MASK_W-1:0] MASK_ROW2      = 4'd1;
    localparam logic [MASK_W-1:0] MASK_COL3      = 4'd2;
    localparam logic [MASK_W-1:0] MASK_RC_SUM3   = 4'd3;
    localparam logic [MASK_W-1:0] MASK_BLOCKS    = 4'd4;
    localparam logic [MASK_W-1:0] MASK_PROD      = 4'd5;
    localparam logic [MASK_W-1:0] MASK_PROD_PAR  = 4'd6;
    localparam logic [MASK_W-1:0] MASK_MIXED_PAR = 4'd7;

    localparam logic [MASK_W-1:0] MASK_NONE = 4'hF;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic home;
        logic step;
    } walk_cmd_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
        logic   reserved;
        logic   full;
    } walk_stat_t;

    // floor(v / 3) for v up to 31 by reciprocal multiply
    function automatic coord_t div3(input coord_t v);
        logic [9:0] prod;
        prod = {5'd0, v} * 10'd11;
        return prod[9:5];
    endfunction

    function automatic logic [1:0] mod3(input coord_t v);
        coord_t q;
        coord_t r;
        q = div3(v);
        r = v - coord_t'({q, 1'b0}) - q;
        return r[1:0];
    endfunction

    // reduce a value below six to its residue mod 3
    function automatic logic [1:0] fold3(input logic [2:0] v);
        logic [2:0] t;
        t = (v >= 3'd3) ? (v - 3'd3) : v;
        return t[1:0];
    endfunction

    function automatic logic mask_hit(input logic [MASK_W-1:0] m, input coord_t r,
                                      input coord_t c);
        logic [1:0] r3;
        logic [1:0] c3;
        logic [1:0] rc3;
        logic [1:0] p3;
        logic [3:0] prod3;
        logic       p2;
        logic       sum2;
        coord_t     cq;
        logic       hit;
        r3    = mod3(r);
        c3    = mod3(c);
        rc3   = fold3({1'b0, r3} + {1'b0, c3});
        prod3 = {2'd0, r3} * {2'd0, c3};
        p3    = fold3(prod3[2:0]);
        p2    = r[0] & c[0];
        sum2  = r[0] ^ c[0];
        cq    = div3(c);
        case (m)
            MASK_RC_SUM2:   hit = !sum2;
            MASK_ROW2:      hit = !r[0];
            MASK_COL3:      hit = (c3 == 2'd0);
            MASK_RC_SUM3:   hit = (rc3 == 2'd0);
            MASK_BLOCKS:    hit = !(r[1] ^ cq[0]);
            MASK_PROD:      hit = !p2 && (p3 == 2'd0);
            MASK_PROD_PAR:  hit = !(p2 ^ p3[0]);
            MASK_MIXED_PAR: hit = !(sum2 ^ p3[0]);
            default:        hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_reserved(input coord_t r, input coord_t c);
        logic lo_r;
        logic lo_c;
        lo_r = (r < coord_t'(FMT_LINE));
        lo_c = (c < coord_t'(FMT_LINE));
        return (r == coord_t'(FMT_LINE)) || (c == coord_t'(FMT_LINE)) ||
               (lo_r && lo_c) ||
               (lo_r && (c > coord_t'(FINDER_HI))) ||
               ((r > coord_t'(FINDER_HI)) && lo_c) ||
               (r == coord_t'(TIMING)) || (c == coord_t'(TIMING));
    endfunction

endpackage

`default_nettype wire

[rtl/qrpm_channels.sv]
// qrpm channel interfaces: input item and result item streams with valid/ready
// depends on qrpm_pkg for field widths
`default_nettype none

interface qrpm_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic data_bit;

    modport source (output valid, output operation, output data_bit, input ready);
    modport sink   (input valid, input operation, input data_bit, output ready);
endinterface

interface qrpm_out_if;
    logic                            valid;
    logic                            ready;
    logic [qrpm_pkg::COORD_W-1:0]    cell_row;
    logic [qrpm_pkg::COORD_W-1:0]    cell_col;
    logic [qrpm_pkg::VALUE_W-1:0]    cell_value;

    modport source (output valid, output cell_row, output cell_col, output cell_value,
                    input ready);
    modport sink   (input valid, input cell_row, input cell_col, input cell_value,
                    output ready);
endinterface

`default_nettype wire

[rtl/qr_module_placement_masker_unit.sv]
// qr_module_placement_masker_unit: top level, sequencer, config registers, result register
// depends on qrpm_pkg, qrpm_channels, qrpm_walker, qrpm_mask_unit
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    operation, data_bit
//  out_ch    out   valid/ready    cell_row, cell_col, cell_value
//  cfg       in    cfg_we only    cfg_index, cfg_data
//
// an item is taken while idle, then the walker visits one cell per cycle up to the next free
// cell or off the grid, holding on a free cell while the result register is stalled; the
// longest walk is where it turns around a finder corner and skips 36 reserved cells in a row
// restart and place items on a full grid finish in the accept cycle with no result
// reset is asynchronous and needs no clearing pass; registers come up as no mask, length 0
// a stalled result holds in the output register; the next item's scan waits on its free cell
`default_nettype none

module qr_module_placement_masker_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    qrpm_in_if.sink                            in_ch,
    qrpm_out_if.source                         out_ch,
    input  wire                                cfg_we,
    input  wire [qrpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [qrpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg, state_next;

    // configuration registers
    logic [qrpm_pkg::MASK_W-1:0]  first_mask_reg;
    logic [qrpm_pkg::MASK_W-1:0]  second_mask_reg;
    logic [qrpm_pkg::COUNT_W-1:0] payload_len_reg;

    // item data and placement count
    logic                         bit_reg, bit_next;
    logic [qrpm_pkg::COUNT_W-1:0] placed_reg, placed_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    qrpm_pkg::coord_t             out_row_reg;
    qrpm_pkg::coord_t             out_col_reg;
    logic [qrpm_pkg::VALUE_W-1:0] out_value_reg;

    qrpm_pkg::walk_cmd_t  walk_cmd;
    qrpm_pkg::walk_stat_t walk_stat;

    logic in_take;
    logic load_out;
    logic out_free;
    logic dark;
    logic [qrpm_pkg::VALUE_W-1:0] value_now;

    qrpm_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (walk_cmd),
        .stat  (walk_stat)
    );

    qrpm_mask_unit u_mask (
        .data_bit    (bit_reg),
        .first_mask  (first_mask_reg),
        .second_mask (second_mask_reg),
        .row         (walk_stat.row),
        .col         (walk_stat.col),
        .dark        (dark)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // dark bits inside the payload read 1, past it 4
    assign value_now = !dark ? qrpm_pkg::VAL_LIGHT :
                       (placed_reg < payload_len_reg) ? qrpm_pkg::VAL_PAYLOAD :
                                                        qrpm_pkg::VAL_PADDING;

    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        placed_next    = placed_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        walk_cmd.home  = 1'b0;
        walk_cmd.step  = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_ch.operation == qrpm_pkg::OP_RESTART)
                    begin
                        walk_cmd.home = 1'b1;
                        placed_next   = '0;
                    end
                    else if (!walk_stat.full)
                    begin
                        bit_next   = in_ch.data_bit;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (walk_stat.full)
                begin
                    // ran past the last free cell: item ends with no result
                    state_next = ST_IDLE;
                end
                else if (walk_stat.reserved)
                begin
                    walk_cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    walk_cmd.step  = 1'b1;
                    placed_next    = placed_reg + qrpm_pkg::COUNT_W'(1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            placed_reg      <= '0;
            out_valid_reg   <= 1'b0;
            first_mask_reg  <= qrpm_pkg::MASK_NONE;
            second_mask_reg <= qrpm_pkg::MASK_NONE;
            payload_len_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            placed_reg    <= placed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    qrpm_pkg::CFG_FIRST_MASK:
                        first_mask_reg <= cfg_data[qrpm_pkg::MASK_W-1:0];
                    qrpm_pkg::CFG_SECOND_MASK:
                        second_mask_reg <= cfg_data[qrpm_pkg::MASK_W-1:0];
                    qrpm_pkg::CFG_PAYLOAD_LEN:
                        payload_len_reg <= cfg_data[qrpm_pkg::COUNT_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        if (load_out)
        begin
            out_row_reg   <= walk_stat.row;
            out_col_reg   <= walk_stat.col;
            out_value_reg <= value_now;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.cell_row   = out_row_reg;
    assign out_ch.cell_col   = out_col_reg;
    assign out_ch.cell_value = out_value_reg;

    // a result is only ever taken from a free cell on a grid that is not full
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!walk_stat.reserved && !walk_stat.full && (state_reg == ST_SCAN)))
    else $error("result loaded from a reserved cell or a full grid");

    // every result counts exactly one placed bit
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (placed_reg == $past(placed_reg) + qrpm_pkg::COUNT_W'(1)))
    else $error("placement count did not advance with a result");

    // a scan that hits the end of the grid returns to idle next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && walk_stat.full) |=> (state_reg == ST_IDLE))
    else $error("scan did not stop at the end of the grid");

    // the cursor never leaves the grid
    assert property (@(posedge clk) disable iff (!rst_n)
        (walk_stat.row <= qrpm_pkg::coord_t'(qrpm_pkg::LAST_IDX)) &&
        (walk_stat.col <= qrpm_pkg::coord_t'(qrpm_pkg::LAST_IDX)))
    else $error("cursor outside the grid");

endmodule

`default_nettype wire

[rtl/qrpm_walker.sv]
// qrpm_walker: zigzag cursor over the grid, one cell step per command
// depends on qrpm_pkg for geometry, walk_cmd_t and walk_stat_t
`default_nettype none

module qrpm_walker (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire qrpm_pkg::walk_cmd_t  cmd,
    output qrpm_pkg::walk_stat_t      stat
);

    qrpm_pkg::coord_t row_reg, row_next;
    qrpm_pkg::coord_t col_reg, col_next;
    logic             side_reg, side_next;
    logic             up_reg, up_next;
    logic             full_reg, full_next;

    qrpm_pkg::coord_t cell_col;
    qrpm_pkg::coord_t col_dec;

    assign cell_col = col_reg - qrpm_pkg::coord_t'(side_reg);
    assign col_dec  = col_reg - qrpm_pkg::coord_t'(qrpm_pkg::PAIR_STEP);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        side_next = side_reg;
        up_next   = up_reg;
        full_next = full_reg;
        if (cmd.home)
        begin
            row_next  = qrpm_pkg::coord_t'(qrpm_pkg::LAST_IDX);
            col_next  = qrpm_pkg::coord_t'(qrpm_pkg::LAST_IDX);
            side_next = 1'b0;
            up_next   = 1'b1;
            full_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (!side_reg)
            begin
                side_next = 1'b1;
            end
            else
            begin
                side_next = 1'b0;
                if (up_reg && (row_reg != '0))
                begin
                    row_next = row_reg - qrpm_pkg::coord_t'(1);
                end
                else if (!up_reg && (row_reg != qrpm_pkg::coord_t'(qrpm_pkg::LAST_IDX)))
                begin
                    row_next = row_reg + qrpm_pkg::coord_t'(1);
                end
                else
                begin
                    // end of pair: turn around, move a pair left or set full
                    up_next = !up_reg;
                    if (col_reg <= qrpm_pkg::coord_t'(qrpm_pkg::LAST_PAIR))
                    begin
                        full_next = 1'b1;
                    end
                    else if (col_dec == qrpm_pkg::coord_t'(qrpm_pkg::TIMING))
                    begin
                        col_next = col_dec - qrpm_pkg::coord_t'(1);
                    end
                    else
                    begin
                        col_next = col_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= qrpm_pkg::coord_t'(qrpm_pkg::LAST_IDX);
            col_reg  <= qrpm_pkg::coord_t'(qrpm_pkg::LAST_IDX);
            side_reg <= 1'b0;
            up_reg   <= 1'b1;
            full_reg <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            side_reg <= side_next;
            up_reg   <= up_next;
            full_reg <= full_next;
        end
    end

    assign stat.row      = row_reg;
    assign stat.col      = cell_col;
    assign stat.reserved = qrpm_pkg::is_reserved(row_reg, cell_col);
    assign stat.full     = full_reg;

endmodule

`default_nettype wire

[rtl/qrpm_mask_unit.sv]
// qrpm_mask_unit: applies the two selected mask patterns to one data bit
// depends on qrpm_pkg for mask_hit and widths
`default_nettype none

module qrpm_mask_unit (
    input  wire                           data_bit,
    input  wire [qrpm_pkg::MASK_W-1:0]    first_mask,
    input  wire [qrpm_pkg::MASK_W-1:0]    second_mask,
    input  wire [qrpm_pkg::COORD_W-1:0]   row,
    input  wire [qrpm_pkg::COORD_W-1:0]   col,
    output logic                          dark
);

    logic hit_a;
    logic hit_b;

    assign hit_a = qrpm_pkg::mask_hit(first_mask, row, col);
    assign hit_b = qrpm_pkg::mask_hit(second_mask, row, col);
    assign dark  = data_bit ^ hit_a ^ hit_b;

endmodule

`default_nettype wire

[tb/sv/tb_qr_module_placement_masker_unit.sv]
// testbench for qr_module_placement_masker_unit: zigzag walk, mask patterns, payload/padding marks
// a built-in walker predicts every placed cell; results are checked in order, field by field
// depends on qrpm_pkg, qrpm_channels and the unit itself
`default_nettype none

module tb_qr_module_placement_masker_unit;

    // per-item wait of either side is drawn from 0..MAX_GAP
    localparam int unsigned MAX_GAP      = 13;
    // margin for a scan that runs off the grid with no result
    localparam int unsigned SETTLE       = 32;
    // receiver hold-off that fills the unit and stalls its input
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned BURST_ITEMS  = 40;
    localparam int unsigned RANDOM_ITEMS = 1300;
    // free cells on the grid, and places past that to push into the full-grid state
    localparam int unsigned FREE_CELLS   = 200;
    localparam int unsigned OVERFLOW_MAX = 12;
    localparam int unsigned RUN_LIMIT    = 6_000_000;

    localparam logic [qrpm_pkg::MASK_W-1:0]  MASK_NEG_MIN = 4'h8;    // -8, acts as no mask
    localparam logic [qrpm_pkg::MASK_W-1:0]  MASK_NEG_TWO = 4'hE;    // -2, acts as no mask
    localparam logic [qrpm_pkg::COUNT_W-1:0] MAX_PAYLOAD  = 9'd441;
    localparam logic [qrpm_pkg::COUNT_W-1:0] FULL_PAYLOAD = 9'd200;  // every free cell is payload

    typedef struct packed {
        qrpm_pkg::coord_t             row;
        qrpm_pkg::coord_t             col;
        logic [qrpm_pkg::VALUE_W-1:0] value;
    } placed_cell_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [qrpm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [qrpm_pkg::CFG_DATA_W-1:0] cfg_data;

    qrpm_in_if  in_ch ();
    qrpm_out_if out_ch ();

    qr_module_placement_masker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor copy of the configuration
    logic [qrpm_pkg::MASK_W-1:0]  mask_a;
    logic [qrpm_pkg::MASK_W-1:0]  mask_b;
    logic [qrpm_pkg::COUNT_W-1:0] payload_len;

    // predictor copy of the walk cursor
    int unsigned                  walk_row;
    int unsigned                  walk_col;       // right column of the current pair
    bit                           walk_left;      // on the left column of the pair
    bit                           walk_up;
    bit                           walk_done;      // walked off the last pair
    logic [qrpm_pkg::COUNT_W-1:0] cells_placed;

    placed_cell_t pending_cells[$];

    int unsigned error_count   = 0;
    int unsigned counted_items = 0;
    bit          no_gaps       = 1'b0;  // both sides run without idling
    bit          long_hold_req = 1'b0;  // ask the receiver for one long hold-off

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // true where the mask pattern inverts the module
    function automatic bit pattern_dark(input logic [qrpm_pkg::MASK_W-1:0] m,
                                        input int unsigned r, input int unsigned c);
        int unsigned p;
        p = r * c;
        case (m)
            qrpm_pkg::MASK_RC_SUM2:   return ((r + c) % 2) == 0;
            qrpm_pkg::MASK_ROW2:      return (r % 2) == 0;
            qrpm_pkg::MASK_COL3:      return (c % 3) == 0;
            qrpm_pkg::MASK_RC_SUM3:   return ((r + c) % 3) == 0;
            qrpm_pkg::MASK_BLOCKS:    return (((r / 2) + (c / 3)) % 2) == 0;
            qrpm_pkg::MASK_PROD:      return ((p % 2) + (p % 3)) == 0;
            qrpm_pkg::MASK_PROD_PAR:  return (((p % 2) + (p % 3)) % 2) == 0;
            qrpm_pkg::MASK_MIXED_PAR: return ((((r + c) % 2) + (p % 3)) % 2) == 0;
            default:                  return 1'b0;  // none, and every negative code
        endcase
    endfunction

    // format lines, finder corners and timing lines are never written
    function automatic bit cell_reserved(input int unsigned r, input int unsigned c);
        if (r == qrpm_pkg::FMT_LINE || c == qrpm_pkg::FMT_LINE) return 1'b1;
        if (r < qrpm_pkg::FMT_LINE && c < qrpm_pkg::FMT_LINE) return 1'b1;
        if (r < qrpm_pkg::FMT_LINE && c > qrpm_pkg::FINDER_HI) return 1'b1;
        if (r > qrpm_pkg::FINDER_HI && c < qrpm_pkg::FMT_LINE) return 1'b1;
        return r == qrpm_pkg::TIMING || c == qrpm_pkg::TIMING;
    endfunction

    function automatic void walk_home();
        walk_row     = qrpm_pkg::LAST_IDX;
        walk_col     = qrpm_pkg::LAST_IDX;
        walk_left    = 1'b0;
        walk_up      = 1'b1;
        walk_done    = 1'b0;
        cells_placed = '0;
    endfunction

    // one step of the two-column zigzag
    function automatic void walk_next();
        if (!walk_left)
        begin
            walk_left = 1'b1;
            return;
        end
        walk_left = 1'b0;
        if (walk_up && walk_row > 0)
        begin
            walk_row--;
        end
        else if (!walk_up && walk_row < qrpm_pkg::LAST_IDX)
        begin
            walk_row++;
        end
        else
        begin
            // turn around at the edge and move to the next pair, hopping the timing column
            walk_up = !walk_up;
            if (walk_col <= qrpm_pkg::LAST_PAIR)
            begin
                walk_done = 1'b1;
            end
            else
            begin
                walk_col -= qrpm_pkg::PAIR_STEP;
                if (walk_col == qrpm_pkg::TIMING) walk_col = qrpm_pkg::TIMING - 1;
            end
        end
    endfunction

    // queues the cell an accepted item writes; returns 0 for a place on a full grid
    function automatic bit predict_item(input logic op, input logic data);
        int unsigned  guard;
        int unsigned  c;
        bit           dark;
        placed_cell_t spot;
        if (op == qrpm_pkg::OP_RESTART)
        begin
            walk_home();
            return 1'b1;
        end
        for (guard = 0; guard < 2 * qrpm_pkg::GRID * qrpm_pkg::GRID && !walk_done; guard++)
        begin
            c = walk_col - walk_left;
            if (!cell_reserved(walk_row, c))
            begin
                dark = data ^ pattern_dark(mask_a, walk_row, c)
                            ^ pattern_dark(mask_b, walk_row, c);
                spot.row   = qrpm_pkg::coord_t'(walk_row);
                spot.col   = qrpm_pkg::coord_t'(c);
                spot.value = !dark ? qrpm_pkg::VAL_LIGHT
                           : (cells_placed < payload_len) ? qrpm_pkg::VAL_PAYLOAD
                                                          : qrpm_pkg::VAL_PADDING;
                pending_cells.push_back(spot);
                cells_placed++;
                walk_next();
                return 1'b1;
            end
            walk_next();
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one item after a random gap, predict it at the accepting edge
    task automatic send_item(input logic op, input logic data);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_bit  <= data;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        if (predict_item(op, data)) counted_items++;
    endtask

    // drop valid, wait out every expected cell, then let any scan that ends
    // without a result run to its end
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // writes all three registers back to back; only called once the unit is idle
    task automatic configure(input logic [qrpm_pkg::MASK_W-1:0] mask1,
                             input logic [qrpm_pkg::MASK_W-1:0] mask2,
                             input logic [qrpm_pkg::COUNT_W-1:0] len);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= qrpm_pkg::CFG_FIRST_MASK;
        cfg_data  <= {{(qrpm_pkg::CFG_DATA_W - qrpm_pkg::MASK_W){mask1[qrpm_pkg::MASK_W-1]}},
                      mask1};
        @(negedge clk);
        cfg_index <= qrpm_pkg::CFG_SECOND_MASK;
        cfg_data  <= {{(qrpm_pkg::CFG_DATA_W - qrpm_pkg::MASK_W){mask2[qrpm_pkg::MASK_W-1]}},
                      mask2};
        @(negedge clk);
        cfg_index <= qrpm_pkg::CFG_PAYLOAD_LEN;
        cfg_data  <= len;
        @(negedge clk);
        cfg_we <= 1'b0;
        mask_a      = mask1;
        mask_b      = mask2;
        payload_len = len;
    endtask

    // mostly real patterns, some no-mask, some raw codes including the negatives
    function automatic logic [qrpm_pkg::MASK_W-1:0] random_mask();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return qrpm_pkg::MASK_W'($urandom_range(0, 7));
        if (pick < 85) return qrpm_pkg::MASK_NONE;
        return qrpm_pkg::MASK_W'($urandom_range(0, 15));
    endfunction

    // short, near-boundary and anywhere in range
    function automatic logic [qrpm_pkg::COUNT_W-1:0] random_length();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick == 0) return qrpm_pkg::COUNT_W'($urandom_range(0, 20));
        if (pick == 1)
            return qrpm_pkg::COUNT_W'($urandom_range(FREE_CELLS - 20, FREE_CELLS + 10));
        return qrpm_pkg::COUNT_W'($urandom_range(0, MAX_PAYLOAD));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset registers: no mask and zero payload length, so dark bits read as padding
    task automatic test_reset_defaults();
        send_item(qrpm_pkg::OP_PLACE, 1'b1);
        send_item(qrpm_pkg::OP_PLACE, 1'b0);
        settle();
    endtask

    // each pattern alone, one 1 and one 0 data bit on consecutive free cells
    task automatic test_mask_patterns();
        for (int k = 0; k < 8; k++)
        begin
            configure(qrpm_pkg::MASK_W'(k), qrpm_pkg::MASK_NONE, MAX_PAYLOAD);
            send_item(qrpm_pkg::OP_PLACE, 1'b1);
            send_item(qrpm_pkg::OP_PLACE, 1'b0);
            settle();
        end
    endtask

    // restart, negative codes, payload/padding boundary, a pattern stacked on itself,
    // and the second mask on its own
    task automatic test_mask_corners();
        send_item(qrpm_pkg::OP_RESTART, 1'b1);
        settle();
        configure(MASK_NEG_MIN, MASK_NEG_TWO, qrpm_pkg::COUNT_W'(1));
        send_item(qrpm_pkg::OP_PLACE, 1'b1);   // index 0, payload
        send_item(qrpm_pkg::OP_PLACE, 1'b1);   // index 1, padding
        settle();
        configure(qrpm_pkg::MASK_PROD, qrpm_pkg::MASK_PROD, '0);
        send_item(qrpm_pkg::OP_PLACE, 1'b1);
        settle();
        configure(qrpm_pkg::MASK_NONE, qrpm_pkg::MASK_MIXED_PAR, MAX_PAYLOAD);
        send_item(qrpm_pkg::OP_PLACE, 1'b0);
        settle();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering items
    task automatic test_result_backpressure();
        configure(random_mask(), random_mask(), random_length());
        send_item(qrpm_pkg::OP_RESTART, 1'b0);
        long_hold_req = 1'b1;
        no_gaps       = 1'b1;
        for (int k = 0; k < BURST_ITEMS; k++)
            send_item(qrpm_pkg::OP_PLACE, 1'($urandom_range(0, 1)));
        no_gaps = 1'b0;
        settle();
    endtask

    // walks from the corner with random bits under fixed, then random settings; some run past the
    // last free cell into the full-grid state, a few restart in the middle
    task automatic test_random_walks();
        int unsigned phase;
        int unsigned count;
        bit          overflow;
        phase         = 0;
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            if (phase == 0)
                configure(MASK_NEG_MIN, qrpm_pkg::MASK_MIXED_PAR, '0);
            else if (phase == 1)
                configure(qrpm_pkg::MASK_MIXED_PAR, qrpm_pkg::MASK_NONE, MAX_PAYLOAD);
            else if (phase == 2)
                configure(qrpm_pkg::MASK_RC_SUM2, qrpm_pkg::MASK_BLOCKS, FULL_PAYLOAD);
            else
                configure(random_mask(), random_mask(), random_length());
            no_gaps  = ($urandom_range(0, 3) == 0);
            overflow = (phase < 3) || ($urandom_range(0, 99) < 40);
            count    = overflow ? $urandom_range(FREE_CELLS, FREE_CELLS + OVERFLOW_MAX)
                                : $urandom_range(10, FREE_CELLS - 1);
            send_item(qrpm_pkg::OP_RESTART, 1'($urandom_range(0, 1)));
            for (int k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 99) < 3)
                    send_item(qrpm_pkg::OP_RESTART, 1'($urandom_range(0, 1)));
                else
                    send_item(qrpm_pkg::OP_PLACE, 1'($urandom_range(0, 1)));
            end
            no_gaps = 1'b0;
            settle();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = qrpm_pkg::CFG_FIRST_MASK;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = qrpm_pkg::OP_RESTART;
        in_ch.data_bit  = 1'b0;
        mask_a          = qrpm_pkg::MASK_NONE;
        mask_b          = qrpm_pkg::MASK_NONE;
        payload_len     = '0;
        walk_home();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_mask_patterns();
        test_mask_corners();
        test_result_backpressure();
        test_random_walks();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: random ready gaps per item, none when no_gaps is set, or the long hold-off when asked
    initial
    begin : result_sink
        int unsigned hold;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req) hold = LONG_HOLD;
            else if (no_gaps) hold = 0;
            else hold = $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
                if (hold == LONG_HOLD) long_hold_req = 1'b0;
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // every accepted result against the oldest predicted cell
    initial
    begin : result_check
        placed_cell_t want;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (pending_cells.size() == 0)
                begin
                    $error("unexpected item: row %0d col %0d value %0d",
                           out_ch.cell_row, out_ch.cell_col, out_ch.cell_value);
                    error_count++;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    if (out_ch.cell_row !== want.row)
                    begin
                        $error("cell_row: expected %0d, got %0d", want.row, out_ch.cell_row);
                        error_count++;
                    end
                    if (out_ch.cell_col !== want.col)
                    begin
                        $error("cell_col: expected %0d, got %0d", want.col, out_ch.cell_col);
                        error_count++;
                    end
                    if (out_ch.cell_value !== want.value)
                    begin
                        $error("cell_value: expected %0d, got %0d", want.value,
                               out_ch.cell_value);
                        error_count++;
                    end
                end
            end
        end
    end

    // hang guard
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/qrpm_pkg.sv
rtl/qrpm_channels.sv
rtl/qrpm_walker.sv
rtl/qrpm_mask_unit.sv
rtl/qr_module_placement_masker_unit.sv
tb/sv/tb_qr_module_placement_masker_unit.sv
